>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is low.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is low.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rpm_pkg.sv
// Types, constants and helper functions of the RS485 polling master.
package rpm_pkg;

  localparam int unsigned REPLY_LEN   = 7;
  localparam int unsigned TX_DEPTH    = 5;
  localparam int unsigned OUT_W       = 28;
  localparam int unsigned TDATA_OUT_W = 32;

  // Index of the last reply byte that enters the reply checksum.
  localparam logic [2:0] RX_SUM_LAST = 3'(REPLY_LEN - 2);

  // Register values after reset.
  localparam logic [7:0] POLL_ADDR_RST      = 8'd23;
  localparam logic [7:0] FUNC_CODE_RST      = 8'hE4;
  localparam logic [1:0] PAYLOAD_COUNT_RST  = 2'd2;
  localparam logic [7:0] PAYLOAD_FIRST_RST  = 8'h55;
  localparam logic [7:0] PAYLOAD_SECOND_RST = 8'hAA;
  localparam logic [7:0] POLL_PERIOD_RST    = 8'd100;
  localparam logic [7:0] RX_IDLE_TICKS_RST  = 8'd5;
  localparam logic [7:0] DRIVE_OFF_RST      = 8'd2;

  typedef enum logic [2:0] {
    REG_POLL_ADDR      = 3'd0,
    REG_FUNC_CODE      = 3'd1,
    REG_PAYLOAD_COUNT  = 3'd2,
    REG_PAYLOAD_FIRST  = 3'd3,
    REG_PAYLOAD_SECOND = 3'd4,
    REG_POLL_PERIOD    = 3'd5,
    REG_RX_IDLE_TICKS  = 3'd6,
    REG_DRIVE_OFF      = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_RX_BYTE  = 2'd1,
    REQ_TX_READY = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_RX_ACC,
    OP_RX_CHECK,
    OP_TX_ACC,
    OP_TX_SEAL,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       close;
    logic       fire;
    logic [2:0] tx_bytes;
  } status_t;

  // Folded checksum: add high and low byte of the sum, invert, keep eight bits.
  function automatic logic [7:0] fold_sum(input logic [10:0] s);
    logic [8:0] t;
    t = {6'b0, s[10:8]} + {1'b0, s[7:0]};
    return ~t[7:0];
  endfunction

endpackage

>>> rtl/core/rpm_ctrl.sv
// Sequencer of the RS485 polling master: item handshake, checksum walks, result register.
module rpm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rpm_pkg::status_t status_i,
  output rpm_pkg::cmd_t    cmd_o
);
  import rpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RX_SUM,
    S_RX_CHECK,
    S_TX_SUM,
    S_TX_SEAL,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [2:0] idx_q;
  logic       fire_q;
  logic       out_valid_q;
  logic       publish;

  assign publish     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_EXEC:     cmd_o.op = OP_EXEC;
      S_RX_SUM:   cmd_o.op = OP_RX_ACC;
      S_RX_CHECK: cmd_o.op = OP_RX_CHECK;
      S_TX_SUM:   cmd_o.op = OP_TX_ACC;
      S_TX_SEAL:  cmd_o.op = OP_TX_SEAL;
      S_DONE:     cmd_o.op = publish ? OP_PUBLISH : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      fire_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx_q  <= '0;
          fire_q <= status_i.fire;
          if (status_i.close) begin
            state_q <= S_RX_SUM;
          end else if (status_i.fire) begin
            state_q <= S_TX_SUM;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RX_SUM: begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == RX_SUM_LAST) begin
            state_q <= S_RX_CHECK;
          end
        end
        S_RX_CHECK: begin
          idx_q   <= '0;
          state_q <= fire_q ? S_TX_SUM : S_DONE;
        end
        S_TX_SUM: begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == status_i.tx_bytes - 3'd1) begin
            state_q <= S_TX_SEAL;
          end
        end
        S_TX_SEAL: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (publish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rpm_datapath.sv
// Datapath of the RS485 polling master: registers, timers, frame stores and checksum adder.
module rpm_datapath #(
  parameter int unsigned RX_LIMIT = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic [1:0]                  item_type_i,
  input  logic [7:0]                  item_data_i,
  input  rpm_pkg::cmd_t               cmd_i,
  output rpm_pkg::status_t            status_o,
  output logic [rpm_pkg::OUT_W-1:0]   out_data_o
);
  import rpm_pkg::*;

  localparam int unsigned CW = $clog2(RX_LIMIT + 1);

  logic [7:0]    poll_addr_q, func_code_q, payload_first_q, payload_second_q;
  logic [1:0]    payload_count_q;
  logic [7:0]    poll_period_q, rx_idle_ticks_q, drive_off_q;

  logic [1:0]    item_type_q;
  logic [7:0]    item_data_q;

  logic [7:0]    rx_store_q [REPLY_LEN];
  logic [CW-1:0] rx_count_q;
  logic [7:0]    rx_idle_q;
  logic          rx_enabled_q;
  logic [7:0]    tx_store_q [TX_DEPTH];
  logic [2:0]    tx_left_q, tx_pos_q;
  logic          tx_busy_q, drive_on_q, off_pending_q;
  logic [7:0]    off_count_q, poll_div_q;
  logic [15:0]   value_held_q;
  logic [10:0]   acc_q;

  logic          res_txv_q, res_upd_q, res_rej_q;
  logic [7:0]    res_txb_q;
  logic [OUT_W-1:0] out_q;

  logic [7:0]    rx_idle_d, poll_div_d, off_count_d;
  logic          close_now, fire_now, is_tick;
  logic [2:0]    tx_bytes;
  logic [7:0]    tx_sel, rx_sel, fold_acc;
  logic [10:0]   acc_d_rx, acc_d_tx;

  assign is_tick   = (item_type_q == REQ_TICK);
  assign rx_idle_d = (rx_idle_q < rx_idle_ticks_q) ? rx_idle_q + 8'd1 : rx_idle_q;
  assign close_now = (rx_idle_d >= rx_idle_ticks_q) && (rx_count_q != '0);
  assign poll_div_d = poll_div_q + 8'd1;
  assign fire_now  = (poll_div_d > poll_period_q);
  assign off_count_d = (off_count_q != 8'd0) ? off_count_q - 8'd1 : off_count_q;

  // Address and function code, then zero to two payload bytes; a count of three means two.
  assign tx_bytes = payload_count_q[1] ? 3'd4 : 3'd2 + {2'b0, payload_count_q[0]};

  assign status_o.close    = is_tick && close_now;
  assign status_o.fire     = is_tick && fire_now;
  assign status_o.tx_bytes = tx_bytes;

  always_comb begin
    case (cmd_i.idx)
      3'd0:    tx_sel = poll_addr_q;
      3'd1:    tx_sel = func_code_q;
      3'd2:    tx_sel = payload_first_q;
      3'd3:    tx_sel = payload_second_q;
      default: tx_sel = 8'd0;
    endcase
  end

  assign rx_sel   = rx_store_q[cmd_i.idx];
  assign acc_d_rx = ((cmd_i.idx == 3'd0) ? 11'd0 : acc_q) + {3'b0, rx_sel};
  assign acc_d_tx = ((cmd_i.idx == 3'd0) ? 11'd0 : acc_q) + {3'b0, tx_sel};
  assign fold_acc = fold_sum(acc_q);

  assign out_data_o = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_addr_q      <= POLL_ADDR_RST;
      func_code_q      <= FUNC_CODE_RST;
      payload_count_q  <= PAYLOAD_COUNT_RST;
      payload_first_q  <= PAYLOAD_FIRST_RST;
      payload_second_q <= PAYLOAD_SECOND_RST;
      poll_period_q    <= POLL_PERIOD_RST;
      rx_idle_ticks_q  <= RX_IDLE_TICKS_RST;
      drive_off_q      <= DRIVE_OFF_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_POLL_ADDR:      poll_addr_q      <= cfg_data_i;
        REG_FUNC_CODE:      func_code_q      <= cfg_data_i;
        REG_PAYLOAD_COUNT:  payload_count_q  <= cfg_data_i[1:0];
        REG_PAYLOAD_FIRST:  payload_first_q  <= cfg_data_i;
        REG_PAYLOAD_SECOND: payload_second_q <= cfg_data_i;
        REG_POLL_PERIOD:    poll_period_q    <= cfg_data_i;
        REG_RX_IDLE_TICKS:  rx_idle_ticks_q  <= cfg_data_i;
        REG_DRIVE_OFF:      drive_off_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Transmit frame store holds no reset value; every entry is written before it is sent.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EXEC && is_tick && fire_now) begin
      tx_store_q[0] <= poll_addr_q;
      tx_store_q[1] <= func_code_q;
      tx_store_q[2] <= payload_first_q;
      tx_store_q[3] <= payload_second_q;
    end else if (cmd_i.op == OP_TX_SEAL) begin
      tx_store_q[tx_bytes] <= fold_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      item_type_q <= item_type_i;
      item_data_q <= item_data_i;
    end
    if (cmd_i.op == OP_RX_ACC) begin
      acc_q <= acc_d_rx;
    end else if (cmd_i.op == OP_TX_ACC) begin
      acc_q <= acc_d_tx;
    end
    if (cmd_i.op == OP_PUBLISH) begin
      out_q <= {res_rej_q, res_upd_q, value_held_q, drive_on_q, res_txb_q, res_txv_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REPLY_LEN; i++) begin
        rx_store_q[i] <= 8'd0;
      end
      rx_count_q    <= '0;
      rx_idle_q     <= RX_IDLE_TICKS_RST;
      rx_enabled_q  <= 1'b1;
      tx_left_q     <= '0;
      tx_pos_q      <= '0;
      tx_busy_q     <= 1'b0;
      drive_on_q    <= 1'b0;
      off_pending_q <= 1'b0;
      off_count_q   <= DRIVE_OFF_RST;
      poll_div_q    <= '0;
      value_held_q  <= '0;
      res_txv_q     <= 1'b0;
      res_txb_q     <= '0;
      res_upd_q     <= 1'b0;
      res_rej_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          res_txv_q <= 1'b0;
          res_txb_q <= '0;
          res_upd_q <= 1'b0;
          res_rej_q <= 1'b0;
        end
        OP_EXEC: begin
          case (item_type_q)
            REQ_TICK: begin
              rx_idle_q <= close_now ? 8'd0 : rx_idle_d;
              if (off_pending_q) begin
                off_count_q <= off_count_d;
                // A poll on the same tick keeps the driver on.
                if (off_count_d == 8'd0 && !fire_now) begin
                  off_pending_q <= 1'b0;
                  drive_on_q    <= 1'b0;
                end
              end
              if (fire_now) begin
                poll_div_q    <= '0;
                tx_pos_q      <= '0;
                tx_left_q     <= tx_bytes + 3'd1;
                tx_busy_q     <= 1'b1;
                rx_enabled_q  <= 1'b0;
                drive_on_q    <= 1'b1;
                off_pending_q <= 1'b0;
              end else begin
                poll_div_q <= poll_div_d;
              end
            end
            REQ_RX_BYTE: begin
              if (rx_enabled_q) begin
                rx_idle_q <= 8'd0;
                if (rx_count_q < CW'(RX_LIMIT)) begin
                  if (rx_count_q < CW'(REPLY_LEN)) begin
                    rx_store_q[rx_count_q[2:0]] <= item_data_q;
                  end
                  rx_count_q <= rx_count_q + CW'(1);
                end
              end
            end
            REQ_TX_READY: begin
              if (tx_busy_q) begin
                if (tx_left_q != 3'd0 && tx_pos_q < 3'(TX_DEPTH)) begin
                  res_txv_q <= 1'b1;
                  res_txb_q <= tx_store_q[tx_pos_q];
                  tx_pos_q  <= tx_pos_q + 3'd1;
                  tx_left_q <= tx_left_q - 3'd1;
                end else begin
                  // Ready after the last byte: hand the line back and start the off delay.
                  tx_left_q     <= '0;
                  rx_enabled_q  <= 1'b1;
                  off_pending_q <= 1'b1;
                  off_count_q   <= drive_off_q;
                  tx_busy_q     <= 1'b0;
                end
              end else begin
                rx_enabled_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_RX_CHECK: begin
          if (rx_store_q[0] == poll_addr_q && fold_acc == rx_store_q[REPLY_LEN-1]) begin
            value_held_q <= {rx_store_q[3], rx_store_q[4]};
            res_upd_q    <= 1'b1;
          end else begin
            res_rej_q <= 1'b1;
          end
          for (int i = 0; i < REPLY_LEN; i++) begin
            rx_store_q[i] <= 8'd0;
          end
          rx_count_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/rs485_poll_master.sv
// Top level of the RS485 polling master: stream ports, configuration port and core wiring.
//
// Each input request is a timer tick, a received byte or a transmitter-ready event, and each
// one yields exactly one result that reports the byte to send, the driver enable level, the
// last accepted control value and whether a reply frame was taken or rejected on that request.
// A received byte, a ready event or a tick that closes no frame and fires no poll passes
// only through the load, execute and done steps. A tick that closes a reply frame adds a walk
// of the reply checksum over six stored bytes, one byte a cycle, and a check step; a tick
// that fires a poll adds a walk of the request checksum over its two to four bytes and a seal
// step. Results leave through an output register, so the next request is taken while a
// result still waits for the sink. Configuration writes are always ready and take effect on
// the next cycle.
module rs485_poll_master #(
  parameter int unsigned RX_LIMIT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_data
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] tx_valid, [8:1] tx_byte, [9] drive_enable, [25:10] ctrl_value,
  // [26] ctrl_updated, [27] frame_rejected, [31:28] zero
  output logic [31:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import rpm_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [OUT_W-1:0] out_data;

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {(TDATA_OUT_W - OUT_W)'(0), out_data};

  rpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rpm_datapath #(
    .RX_LIMIT (RX_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_type_i (s_axis_tuser_i),
    .item_data_i (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data)
  );

endmodule

>>> rtl/core/rpm_checker.sv
// Port-level checker of the RS485 polling master and its bind to the top level.
`include "assert_macros.svh"

module rpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i
);

  // A result that is offered stays offered and unchanged until the sink takes it.
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped before it was taken")
  `CHK_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")

  // One request is worked on at a time, so the input closes right after a request.
  `CHK_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "request taken while another is in work")

  // A reply frame is either taken or rejected, never both, and no byte goes out unflagged.
  `CHK_ASSERT(a_flags, clk_i, rst_ni, m_axis_tvalid_o |-> !(m_axis_tdata_o[26] && m_axis_tdata_o[27]) && (m_axis_tdata_o[0] || m_axis_tdata_o[8:1] == 8'd0), "inconsistent result flags")

  `CHK_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result offered during reset")

endmodule

bind rs485_poll_master rpm_checker u_rpm_checker (.*);
